[sv/uatx_pkg.sv]
package uatx_pkg;

    // Item kinds carried in the action field of an input beat.
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_CTS   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DATA_LEN  = 3'd0,
        CFG_STOP_SEL  = 3'd1,
        CFG_PARITY_EN = 3'd2,
        CFG_TX_EN     = 3'd3,
        CFG_FLOW_EN   = 3'd4,
        CFG_DIVIDER   = 3'd5,
        CFG_IRQ_EN    = 3'd6
    } t_cfg_index;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned FLAG_W     = 5;

    // Shortest data length; data_length_sel is added to it.
    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    // Stop bits are stop_bit_sel plus this.
    localparam logic [1:0] STOP_BITS_MIN = 2'd1;

    // Requests from the frame logic to the byte queue.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_ctl;

    // Single-bit result fields, in tdata order from bit 4 down to bit 0.
    typedef struct packed {
        logic ovf;
        logic irq;
        logic req;
        logic busy;
        logic tx_line;
    } t_res_flags;

endpackage

[sv/uatx_fifo.sv]
module uatx_fifo
    import uatx_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_fifo_ctl                    i_ctl,
    input  logic [7:0]                   i_wdata,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [7:0]                   o_head_byte
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_head_byte;
    logic [SW-1:0] wr_sum;
    logic [AW-1:0] wr_addr;

    // Tail slot is head plus count, folded once since the sum stays below twice the depth.
    always_comb begin
        wr_sum = SW'(r_head) + SW'(r_count);
        if (wr_sum >= SW'(DEPTH)) begin
            wr_sum = wr_sum - SW'(DEPTH);
        end
        wr_addr = wr_sum[AW-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else begin
            if (i_ctl.pop) begin
                n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                n_count = r_count - CW'(1);
            end
            if (i_ctl.push) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // The byte at the next head is read ahead, with a bypass for a write to that slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[wr_addr] <= i_wdata;
        end
        if (i_ctl.push && (wr_addr == n_head)) begin
            r_head_byte <= i_wdata;
        end else begin
            r_head_byte <= r_mem[n_head];
        end
    end

    assign o_count     = r_count;
    assign o_head_byte = r_head_byte;

endmodule

[sv/uatx_core.sv]
module uatx_core
    import uatx_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_fire,
    input  t_action                       i_action,
    input  logic                          i_cts_level,
    input  logic [$clog2(DEPTH+1)-1:0]    i_fifo_count,
    input  logic [7:0]                    i_head_byte,
    output t_fifo_ctl                     o_fifo_ctl,
    output t_res_flags                    o_flags,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DATA   = 2'd1,
        PH_PARITY = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    logic [1:0]  r_data_len;
    logic        r_stop_sel;
    logic        r_parity_en;
    logic        r_tx_en;
    logic        r_flow_en;
    logic [15:0] r_divider;
    logic        r_irq_en;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_shift,      n_shift;
    logic [3:0]  r_bits_left,  n_bits_left;
    logic [1:0]  r_stops_left, n_stops_left;
    logic        r_parity,     n_parity;
    logic        r_cts,        n_cts;
    logic        r_may_send,   n_may_send;
    logic        r_armed,      n_armed;
    logic [16:0] r_countdown,  n_countdown;
    logic        r_line,       n_line;

    logic [CW-1:0] n_count;
    logic          do_check;
    logic          bit_out;
    t_fifo_ctl     ctl;
    t_res_flags    flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len  <= 2'd3;
            r_stop_sel  <= 1'b0;
            r_parity_en <= 1'b0;
            r_tx_en     <= 1'b0;
            r_flow_en   <= 1'b0;
            r_divider   <= '0;
            r_irq_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_LEN:  r_data_len  <= i_cfg_data[1:0];
                CFG_STOP_SEL:  r_stop_sel  <= i_cfg_data[0];
                CFG_PARITY_EN: r_parity_en <= i_cfg_data[0];
                CFG_TX_EN:     r_tx_en     <= i_cfg_data[0];
                CFG_FLOW_EN:   r_flow_en   <= i_cfg_data[0];
                CFG_DIVIDER:   r_divider   <= i_cfg_data[15:0];
                CFG_IRQ_EN:    r_irq_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_bits_left  = r_bits_left;
        n_stops_left = r_stops_left;
        n_parity     = r_parity;
        n_cts        = r_cts;
        n_may_send   = r_may_send;
        n_armed      = r_armed;
        n_countdown  = r_countdown;
        n_line       = r_line;
        n_count      = i_fifo_count;
        do_check     = 1'b0;
        bit_out      = 1'b1;
        ctl          = '0;
        flags        = '0;

        if (i_fire) begin
            case (i_action)
                ACT_PUSH: begin
                    if (i_fifo_count < CW'(DEPTH)) begin
                        ctl.push = 1'b1;
                        n_count  = i_fifo_count + CW'(1);
                    end else begin
                        flags.ovf = 1'b1;
                    end
                    do_check = 1'b1;
                end
                ACT_TICK: begin
                    if (r_armed) begin
                        if (r_countdown != '0) begin
                            n_countdown = r_countdown - 17'd1;
                        end
                        if (n_countdown == '0) begin
                            n_armed  = 1'b0;
                            do_check = 1'b1;
                            // One step of the frame machine drives one bit.
                            case (r_phase)
                                PH_START: begin
                                    n_parity = 1'b0;
                                    if ((i_fifo_count != '0) && r_may_send) begin
                                        ctl.pop     = 1'b1;
                                        n_count     = i_fifo_count - CW'(1);
                                        n_shift     = i_head_byte;
                                        n_bits_left = {2'b00, r_data_len} + DATA_BITS_MIN;
                                        n_phase     = PH_DATA;
                                        bit_out     = 1'b0;
                                    end
                                end
                                PH_DATA: begin
                                    bit_out  = r_shift[0];
                                    n_shift  = {1'b0, r_shift[7:1]};
                                    n_parity = r_parity ^ r_shift[0];
                                    if (r_bits_left != '0) begin
                                        n_bits_left = r_bits_left - 4'd1;
                                    end
                                    if (n_bits_left == '0) begin
                                        n_stops_left = {1'b0, r_stop_sel} + STOP_BITS_MIN;
                                        n_phase      = r_parity_en ? PH_PARITY : PH_STOP;
                                    end
                                end
                                PH_PARITY: begin
                                    bit_out = r_parity;
                                    n_phase = PH_STOP;
                                end
                                PH_STOP: begin
                                    if (r_stops_left != '0) begin
                                        n_stops_left = r_stops_left - 2'd1;
                                    end
                                    if (n_stops_left == '0) begin
                                        n_phase = PH_START;
                                    end
                                    flags.req = 1'b1;
                                    flags.irq = r_irq_en;
                                end
                                default: ;
                            endcase
                            if (r_tx_en) begin
                                n_line = bit_out;
                            end
                        end
                    end
                end
                ACT_CTS: begin
                    n_cts    = i_cts_level;
                    do_check = 1'b1;
                end
                ACT_CLEAR: begin
                    n_line       = 1'b1;
                    n_phase      = PH_START;
                    n_bits_left  = '0;
                    n_stops_left = '0;
                    n_parity     = 1'b0;
                    n_cts        = 1'b0;
                    ctl.clear    = 1'b1;
                    n_count      = '0;
                    n_armed      = 1'b0;
                    n_countdown  = '0;
                end
                default: ;
            endcase

            // Re-evaluate the send permission and arm the bit timer when work waits.
            if (do_check) begin
                n_may_send = !r_flow_en || !n_cts;
                if ((((n_count != '0) && n_may_send) || (n_bits_left != '0)
                        || (n_stops_left != '0)) && !n_armed) begin
                    n_armed     = 1'b1;
                    n_countdown = {1'b0, r_divider} + 17'd1;
                end
            end
        end

        flags.tx_line = n_line;
        flags.busy    = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_shift      <= '0;
            r_bits_left  <= '0;
            r_stops_left <= '0;
            r_parity     <= 1'b0;
            r_cts        <= 1'b0;
            r_may_send   <= 1'b1;
            r_armed      <= 1'b0;
            r_countdown  <= '0;
            r_line       <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_bits_left  <= n_bits_left;
            r_stops_left <= n_stops_left;
            r_parity     <= n_parity;
            r_cts        <= n_cts;
            r_may_send   <= n_may_send;
            r_armed      <= n_armed;
            r_countdown  <= n_countdown;
            r_line       <= n_line;
        end
    end

    assign o_fifo_ctl = ctl;
    assign o_flags    = flags;
    assign o_level    = n_count;

endmodule

[sv/uart_transmitter.sv]
// UART transmitter with a byte queue. Every input beat is one item: a push of a byte, a
// tick of the peripheral clock, a new clear-to-send level, or a clear; every item gives
// exactly one result beat with the line level, the busy flag, the stop-bit pulses for
// data request and interrupt, a dropped-push flag and the queue level. A bit lasts
// clock_divider+1 ticks; a frame is a low start bit, 5 to 8 data bits LSB first, an
// optional even parity bit and one or two high stop bits. The block takes one beat per
// clock cycle without gaps: an item is registered on entry, its whole state update is
// done when it moves on from that register, and its result is registered for the output
// in the same cycle. Doing the whole state update at once, together with the queue's head
// byte being read ahead into a register, sets the rate. Backpressure on the result side
// stalls the input side only once both registers are full. Configuration writes are meant
// for idle periods, when no result is pending.
module uart_transmitter
    import uatx_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: action[1:0], data_byte[9:2], cts_level[10], zeros above.
    input  logic [IN_DATA_W-1:0]         s_axis_tdata,

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: tx_line, busy_res, data_request, irq_pulse, overflow,
    // fifo_level[5 +: clog2(FIFO_DEPTH+1)], zeros above.
    output logic [((FLAG_W+$clog2(FIFO_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,

    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned CW    = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned OUT_W = ((FLAG_W + CW + 7) / 8) * 8;

    logic                 r_in_valid;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic [OUT_W-1:0]     result;
    logic                 advance;

    t_fifo_ctl            fifo_ctl;
    t_res_flags           flags;
    logic [CW-1:0]        fifo_count;
    logic [CW-1:0]        level;
    logic [7:0]           head_byte;

    // The registered item moves on when the result register is empty or being emptied.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    uatx_core #(
        .DEPTH (FIFO_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (advance),
        .i_action     (t_action'(r_in_data[1:0])),
        .i_cts_level  (r_in_data[10]),
        .i_fifo_count (fifo_count),
        .i_head_byte  (head_byte),
        .o_fifo_ctl   (fifo_ctl),
        .o_flags      (flags),
        .o_level      (level)
    );

    uatx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .i_wdata     (r_in_data[9:2]),
        .o_count     (fifo_count),
        .o_head_byte (head_byte)
    );

    always_comb begin
        result               = '0;
        result[FLAG_W-1:0]   = flags;
        result[FLAG_W +: CW] = level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[sv/uatx_chk.sv]
module uatx_chk
    import uatx_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input logic                                             i_clk,
    input logic                                             i_rst_n,
    input logic                                             m_axis_tvalid,
    input logic                                             m_axis_tready,
    input logic [((FLAG_W+$clog2(FIFO_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    logic [CW-1:0] level;
    logic          req;
    logic          irq;
    logic          ovf;

    assign req   = m_axis_tdata[2];
    assign irq   = m_axis_tdata[3];
    assign ovf   = m_axis_tdata[4];
    assign level = m_axis_tdata[FLAG_W +: CW];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> level <= CW'(FIFO_DEPTH))
        else $error("queue level above depth");

    a_irq_with_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && irq |-> req)
        else $error("interrupt pulse without data request");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ovf |-> level == CW'(FIFO_DEPTH))
        else $error("dropped push while queue not full");

endmodule

bind uart_transmitter uatx_chk #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_uatx_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
